FILE: design/fdf_pkg.sv
// shared types and constants for the direct-form fir filter
package fdf_pkg;

  localparam int ACC_W = 64;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic coef_load;
    logic push;
    logic issue;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic taps_zero;
    logic tap_last;
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/fdf_in_if.sv
// request channel carrying coefficient loads and samples
interface fdf_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [7:0]                   tap_index;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         restart;

  modport source (output valid, output cmd, output tap_index, output value,
                  output restart, input ready);
  modport sink   (input valid, input cmd, input tap_index, input value,
                  input restart, output ready);
endinterface

FILE: design/fdf_out_if.sv
// result channel carrying filter outputs
interface fdf_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] filtered;
  logic                         clipped;

  modport source (output valid, output filtered, output clipped, input ready);
  modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

FILE: design/fdf_ctrl.sv
// controller state machine sequencing clear, load, multiply-accumulate and output
module fdf_ctrl import fdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.clr_step  = (state_r == ST_CLEAR);
    cmd.coef_load = accept && (in_cmd == CMD_LOAD);
    cmd.push      = accept && (in_cmd == CMD_SAMPLE);
    cmd.issue     = (state_r == ST_MAC);
    cmd.out_load  = (state_r == ST_OUT) && status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.push) state_nxt = status.taps_zero ? ST_DRAIN : ST_MAC;
      end
      ST_MAC: begin
        if (status.tap_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/fdf_dp.sv
// datapath: coefficient and history memories, shared multiply-accumulate, rounding
module fdf_dp import fdf_pkg::*; #(
  parameter int MAX_TAPS   = 256,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctrl_cmd_t                    cmd,
  output dp_status_t                   status,
  input  logic [7:0]                   in_tap_index,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_restart,
  input  logic                         cfg_wr_en,
  input  logic [8:0]                   cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_filtered,
  output logic                         out_clipped
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int FRAC  = DATA_WIDTH - 1;
  localparam int PW    = 2 * DATA_WIDTH;

  logic signed [DATA_WIDTH-1:0] coef_mem [MAX_TAPS];
  logic signed [DATA_WIDTH-1:0] hist_mem [MAX_TAPS];

  logic [8:0]                   active_r;
  logic [AW-1:0]                clr_r;
  logic [AW-1:0]                ptr_r;
  logic [AW-1:0]                cur_r;
  logic [CNT_W-1:0]             fill_r;
  logic [CNT_W-1:0]             j_r;
  logic signed [DATA_WIDTH-1:0] coef_q_r;
  logic signed [DATA_WIDTH-1:0] hist_q_r;
  logic                         v1_r;
  logic                         en1_r;
  logic                         v2_r;
  logic signed [PW-1:0]         prod_r;
  logic [ACC_W-1:0]             acc_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] filtered_r;
  logic                         clipped_r;

  logic [CNT_W-1:0]             taps_eff;
  logic [AW-1:0]                wr_slot;
  logic [AW-1:0]                rd_slot;
  logic [AW-1:0]                jj;
  logic                         coef_we;
  logic [AW-1:0]                coef_addr;
  logic signed [DATA_WIDTH-1:0] coef_wdata;
  logic signed [PW-1:0]         prod_w;
  logic [ACC_W-1:0]             rnd_sum;
  logic signed [ACC_W-1:0]      rnd_sh;
  logic [ACC_W-DATA_WIDTH:0]    rnd_top;
  logic                         fits;
  logic signed [DATA_WIDTH-1:0] y_w;
  logic                         clip_w;

  // tap count clamped to the store depth
  assign taps_eff = (32'(active_r) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(active_r);

  assign jj = j_r[AW-1:0];

  always_comb begin
    if ({1'b0, cur_r} >= {1'b0, jj}) begin
      rd_slot = cur_r - jj;
    end else begin
      rd_slot = AW'({1'b0, cur_r} + (AW + 1)'(MAX_TAPS) - {1'b0, jj});
    end
  end

  assign wr_slot = in_restart ? '0 : ptr_r;

  always_comb begin
    if (cmd.clr_step) begin
      coef_we    = 1'b1;
      coef_addr  = clr_r;
      coef_wdata = '0;
    end else begin
      coef_we    = cmd.coef_load && (32'(in_tap_index) < 32'(MAX_TAPS));
      coef_addr  = AW'(in_tap_index);
      coef_wdata = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_addr] <= coef_wdata;
    coef_q_r <= coef_mem[jj];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) hist_mem[wr_slot] <= in_value;
    hist_q_r <= hist_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 9'd256;
      clr_r    <= '0;
      ptr_r    <= '0;
      cur_r    <= '0;
      fill_r   <= '0;
      j_r      <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      en1_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) active_r <= cfg_wr_data;
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      if (cmd.push) begin
        cur_r <= wr_slot;
        ptr_r <= (wr_slot == AW'(MAX_TAPS - 1)) ? '0 : wr_slot + AW'(1);
        if (in_restart) begin
          fill_r <= CNT_W'(1);
        end else if (fill_r != CNT_W'(MAX_TAPS)) begin
          fill_r <= fill_r + CNT_W'(1);
        end
        j_r <= '0;
      end else if (cmd.issue) begin
        j_r <= j_r + CNT_W'(1);
      end
      v1_r  <= cmd.issue;
      en1_r <= cmd.issue && (j_r < fill_r);
      v2_r  <= v1_r;
    end
  end

  // history slots not yet written since the signal start count as zero
  assign prod_w = PW'(coef_q_r) * PW'(hist_q_r);

  always_ff @(posedge clk) begin
    prod_r <= en1_r ? prod_w : '0;
    if (cmd.push) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd_sum = acc_r + (ACC_W'(1) << (FRAC - 1));
    rnd_sh  = $signed(rnd_sum) >>> FRAC;
    rnd_top = rnd_sh[ACC_W-1:DATA_WIDTH-1];
    fits    = (&rnd_top) || !(|rnd_top);
    clip_w  = !fits;
    if (fits) begin
      y_w = rnd_sh[DATA_WIDTH-1:0];
    end else if (rnd_sh[ACC_W-1]) begin
      y_w = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      y_w = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_r <= y_w;
      clipped_r  <= clip_w;
    end
  end

  always_comb begin
    status.clr_last   = (clr_r == AW'(MAX_TAPS - 1));
    status.taps_zero  = (taps_eff == '0);
    status.tap_last   = (j_r == taps_eff - CNT_W'(1));
    status.pipe_empty = !v1_r && !v2_r;
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = filtered_r;
  assign out_clipped  = clipped_r;

endmodule

FILE: design/fir_filter_direct_form_top.sv
// direct-form fir filter top level
//
//   channel  dir  contents                                  handshake
//   in_ch    in   cmd, tap_index, value, restart            valid/ready
//   out_ch   out  filtered, clipped                         valid/ready
//   cfg      in   active_taps                               cfg_wr_en, no wait
//
// a coefficient load is written as it is accepted; a sample is processed by the
// single multiply-accumulate unit walking one tap per cycle; zero taps skip it
// after reset the coefficient memory is zeroed while no request is taken
// a result waits in the output register; the next request is accepted meanwhile
// and that sample stalls before its output stage until the register is taken
module fir_filter_direct_form_top import fdf_pkg::*; #(
  parameter int MAX_TAPS   = 256,
  parameter int DATA_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  fdf_in_if.sink           in_ch,
  fdf_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [8:0]       cfg_wr_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fdf_dp #(
    .MAX_TAPS   (MAX_TAPS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_tap_index (in_ch.tap_index),
    .in_value     (in_ch.value),
    .in_restart   (in_ch.restart),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_filtered (out_ch.filtered),
    .out_clipped  (out_ch.clipped)
  );

endmodule
